// File: hw/rtl/ace_pkg.sv
package ace_pkg;

  localparam int unsigned HistDepthDefault = 10;

  // Fixed-point gains, Q0.16.
  localparam logic [15:0] GainPos   = 16'd39322;
  localparam logic [15:0] GainVel   = 16'd7864;
  localparam logic [15:0] GainAcc   = 16'd524;
  localparam logic [15:0] GainInt   = 16'd11796;
  localparam logic [15:0] HoverKeep = 16'd64881;
  localparam logic [15:0] HoverTake = 16'd655;

  // Gravity in Q16.16 m/s^2 and limits.
  localparam logic signed [33:0] GravityQ16  = 34'sd642689;
  localparam logic [25:0]        HoverMax    = 26'd65536000;
  localparam logic [25:0]        HoverReset  = 26'd26214400;
  localparam logic signed [15:0] AngleLimit  = 16'sd500;
  localparam logic signed [31:0] SpeedLimit  = 32'sd3932160;

  // Configuration register indexes.
  localparam logic [1:0] CfgSamplePeriod = 2'd0;
  localparam logic [1:0] CfgBaroAlpha    = 2'd1;
  localparam logic [1:0] CfgIdleThrottle = 2'd2;
  localparam logic [1:0] CfgInitialHover = 2'd3;

  localparam logic signed [67:0] Max32 = 68'sd2147483647;
  localparam logic signed [67:0] Min32 = -68'sd2147483648;

  // Sign-extend a 32-bit value to the wide accumulator width.
  function automatic logic signed [67:0] sx32(input logic [31:0] x);
    sx32 = $signed({{36{x[31]}}, x});
  endfunction

  // Saturate a wide value to signed 32 bits.
  function automatic logic [31:0] sat32(input logic signed [67:0] x);
    if (x > Max32) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (x < Min32) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

  // Round to nearest by a right shift, ties toward plus infinity.
  function automatic logic signed [67:0] rnd(input logic signed [67:0] x,
                                             input int unsigned sh);
    logic signed [67:0] half;
    half = 68'sd1 <<< (sh - 1);
    rnd = (x + half) >>> sh;
  endfunction

endpackage

// File: hw/rtl/ace_mul.sv
module ace_mul
  import ace_pkg::*;
(
  input  logic               clk_i,
  input  logic signed [33:0] a_i,
  input  logic signed [33:0] b_i,
  output logic signed [67:0] p_o
);

  logic signed [67:0] p_q;

  // Registered signed product, one per cycle.
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// File: hw/rtl/altitude_complementary_estimator.sv
// Altitude complementary estimator.
// Input channel: in_valid_i with in_stall_o; an item is taken when valid is
// high and stall is low. Output channel: out_valid_o with out_stall_i; one
// result item per input item, held stable while the receiver stalls.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i at the
// clock edge; writing the initial hover value also reloads the hover estimate.
// Sequencing: an item with system_ready high runs through the multiply and
// write-back states to StDone; one with system_ready low goes from StIdle
// straight to StDone, where the result register is loaded once it is free.
// The sequencer runs its 14 products, one at a time, through the single
// shared 34x34 multiplier; each is registered and then written back or
// used as an operand of the next product. The block takes no new item
// while it works on one. The result stays in the output register, and a
// new item may be accepted meanwhile; if the receiver still stalls when the
// next result is done, the sequencer waits.
// Reset clears all filter state, loads the default register values and sets
// the hover estimate to the initial hover value.
module altitude_complementary_estimator
  import ace_pkg::*;
#(
  parameter int unsigned HistoryDepth = HistDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] height_cm_i,
  input  logic signed [31:0] accel_z_mss_i,
  input  logic signed [15:0] roll_cdeg_i,
  input  logic signed [15:0] pitch_cdeg_i,
  input  logic signed [15:0] throttle_cmd_i,
  input  logic               system_ready_i,
  input  logic               armed_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               valid_res_o,
  output logic signed [31:0] position_est_o,
  output logic signed [31:0] velocity_est_o,
  output logic [25:0]        hover_throttle_o
);

  localparam logic [4:0] StIdle = 5'd0;
  localparam logic [4:0] StAccM = 5'd1;
  localparam logic [4:0] StAccW = 5'd2;
  localparam logic [4:0] StBarM = 5'd3;
  localparam logic [4:0] StBarW = 5'd4;
  localparam logic [4:0] StErr  = 5'd5;
  localparam logic [4:0] StGaM  = 5'd6;
  localparam logic [4:0] StEaM  = 5'd7;
  localparam logic [4:0] StEaW  = 5'd8;
  localparam logic [4:0] StGvM  = 5'd9;
  localparam logic [4:0] StEvM  = 5'd10;
  localparam logic [4:0] StEvW  = 5'd11;
  localparam logic [4:0] StGpM  = 5'd12;
  localparam logic [4:0] StEpM  = 5'd13;
  localparam logic [4:0] StEpW  = 5'd14;
  localparam logic [4:0] StViM  = 5'd15;
  localparam logic [4:0] StViW  = 5'd16;
  localparam logic [4:0] StPbM  = 5'd17;
  localparam logic [4:0] StPbW  = 5'd18;
  localparam logic [4:0] StPvM  = 5'd19;
  localparam logic [4:0] StPvW  = 5'd20;
  localparam logic [4:0] StHiM  = 5'd21;
  localparam logic [4:0] StHiW  = 5'd22;
  localparam logic [4:0] StHv1M = 5'd23;
  localparam logic [4:0] StHv2M = 5'd24;
  localparam logic [4:0] StHvW  = 5'd25;
  localparam logic [4:0] StDone = 5'd26;

  logic [4:0]  state_q, state_d;

  // Configuration registers.
  logic [15:0] dt_q, alpha_q;
  logic [9:0]  idle_q;

  // Latched input item.
  logic [31:0] height_q, accel_q;
  logic signed [15:0] roll_q, pitch_q, thr_q;
  logic        ready_q, armed_q;

  // Filter state.
  logic [31:0] bf_q, pc_q, pbase_q, hi_q, abc_q, pv_q, vel_q;
  logic [25:0] hv_q;
  logic [31:0] hist_q [HistoryDepth];

  // Scratch values.
  logic [31:0] acc_ef_q, err_q, vinc_q;
  logic signed [67:0] tmp_q;

  // Result register.
  logic        out_valid_q, res_valid_q;
  logic [31:0] res_pos_q, res_vel_q;
  logic [25:0] res_hov_q;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;

  logic        in_acc;
  logic        out_free;
  logic        hover_ok;
  logic signed [67:0] hov_r;
  logic [25:0] hov_new;
  logic [25:0] cfg_hov;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign out_free = !out_valid_q || !out_stall_i;

  ace_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StAccM: begin
        mul_a = $signed({{2{accel_q[31]}}, accel_q}) + GravityQ16;
        mul_b = 34'sd100;
      end
      StBarM: begin
        mul_a = $signed({{2{height_q[31]}}, height_q}) - $signed({{2{bf_q[31]}}, bf_q});
        mul_b = $signed({18'd0, alpha_q});
      end
      StGaM: begin
        mul_a = $signed({18'd0, dt_q});
        mul_b = $signed({18'd0, GainAcc});
      end
      StGvM: begin
        mul_a = $signed({18'd0, dt_q});
        mul_b = $signed({18'd0, GainVel});
      end
      StGpM: begin
        mul_a = $signed({18'd0, dt_q});
        mul_b = $signed({18'd0, GainPos});
      end
      StEaM, StEvM, StEpM: begin
        mul_a = $signed({{2{err_q[31]}}, err_q});
        mul_b = $signed({2'd0, prod[31:0]});
      end
      StViM: begin
        mul_a = $signed({{2{acc_ef_q[31]}}, acc_ef_q}) + $signed({{2{abc_q[31]}}, abc_q});
        mul_b = $signed({18'd0, dt_q});
      end
      StPbM: begin
        mul_a = $signed({vel_q[31], vel_q, 1'b0}) + $signed({{2{vinc_q[31]}}, vinc_q});
        mul_b = $signed({18'd0, dt_q});
      end
      StPvM: begin
        mul_a = $signed({{2{hi_q[31]}}, hi_q});
        mul_b = $signed({18'd0, GainInt});
      end
      StHiM: begin
        mul_a = $signed({{2{bf_q[31]}}, bf_q}) - $signed({{2{pv_q[31]}}, pv_q});
        mul_b = $signed({18'd0, dt_q});
      end
      StHv1M: begin
        mul_a = $signed({8'd0, hv_q});
        mul_b = $signed({18'd0, HoverKeep});
      end
      StHv2M: begin
        mul_a = $signed({{18{thr_q[15]}}, thr_q});
        mul_b = $signed({18'd0, HoverTake});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Hover update condition and clamped new hover value.
  assign hover_ok = ($signed(thr_q) > $signed({6'd0, idle_q})) &&
                    ($signed(vel_q) < SpeedLimit) && ($signed(vel_q) > -SpeedLimit) &&
                    (roll_q < AngleLimit) && (roll_q > -AngleLimit) &&
                    (pitch_q < AngleLimit) && (pitch_q > -AngleLimit);
  assign hov_r = rnd(tmp_q + (prod <<< 16), 16);

  always_comb begin
    if (hov_r < 68'sd0) begin
      hov_new = '0;
    end else if (hov_r > $signed({42'd0, HoverMax})) begin
      hov_new = HoverMax;
    end else begin
      hov_new = hov_r[25:0];
    end
  end

  // Initial hover from the configuration port, clamped to the hover range.
  assign cfg_hov = ({cfg_data_i[9:0], 16'd0} > HoverMax) ? HoverMax
                                                         : {cfg_data_i[9:0], 16'd0};

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = system_ready_i ? StAccM : StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = state_q + 5'd1;
      end
    endcase
  end

  // Item latch.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      height_q <= height_cm_i;
      accel_q  <= accel_z_mss_i;
      roll_q   <= roll_cdeg_i;
      pitch_q  <= pitch_cdeg_i;
      thr_q    <= throttle_cmd_i;
      ready_q  <= system_ready_i;
      armed_q  <= armed_i;
    end
  end

  // Scratch registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StAccW:  acc_ef_q <= sat32(-prod);
      StErr:   err_q    <= sat32(sx32(bf_q) - sx32(hist_q[0]) - sx32(pc_q));
      StViW:   vinc_q   <= sat32(rnd(prod, 16));
      StHv2M:  tmp_q    <= prod;
      default: begin
      end
    endcase
  end

  // Control, configuration and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      dt_q    <= 16'd164;
      alpha_q <= 16'd28835;
      idle_q  <= 10'd100;
      bf_q    <= '0;
      pc_q    <= '0;
      pbase_q <= '0;
      hi_q    <= '0;
      abc_q   <= '0;
      pv_q    <= '0;
      vel_q   <= '0;
      hv_q    <= HoverReset;
      for (int i = 0; i < HistoryDepth; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgSamplePeriod: dt_q    <= cfg_data_i;
          CfgBaroAlpha:    alpha_q <= cfg_data_i;
          CfgIdleThrottle: idle_q  <= cfg_data_i[9:0];
          CfgInitialHover: hv_q    <= cfg_hov;
          default: begin
          end
        endcase
      end
      case (state_q)
        StBarW: bf_q <= sat32(sx32(bf_q) + rnd(prod, 16));
        StErr: begin
          // Disarmed: re-seed the estimator from the filtered height.
          if (!armed_q) begin
            pbase_q <= bf_q;
            pv_q    <= bf_q;
            abc_q   <= sat32(-sx32(acc_ef_q));
            vel_q   <= '0;
            hi_q    <= '0;
          end
        end
        StEaW: abc_q   <= sat32(sx32(abc_q) + rnd(prod, 32));
        StEvW: vel_q   <= sat32(sx32(vel_q) + rnd(prod, 32));
        StEpW: pc_q    <= sat32(sx32(pc_q) + rnd(prod, 32));
        StPbW: pbase_q <= sat32(sx32(pbase_q) + rnd(prod, 17));
        StPvW: pv_q    <= sat32(sx32(pbase_q) + sx32(pc_q) + rnd(prod, 16));
        StHiW: begin
          hi_q  <= sat32(sx32(hi_q) + rnd(prod, 16));
          vel_q <= sat32(sx32(vel_q) + sx32(vinc_q));
          // Shift the base-position history by one tick.
          for (int i = 0; i < HistoryDepth - 1; i++) begin
            hist_q[i] <= hist_q[i + 1];
          end
          hist_q[HistoryDepth - 1] <= pbase_q;
        end
        StHvW: begin
          if (hover_ok) begin
            hv_q <= hov_new;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == StDone && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StDone && out_free) begin
      res_valid_q <= ready_q;
      res_pos_q   <= pv_q;
      res_vel_q   <= vel_q;
      res_hov_q   <= hv_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign valid_res_o      = res_valid_q;
  assign position_est_o   = res_pos_q;
  assign velocity_est_o   = res_vel_q;
  assign hover_throttle_o = res_hov_q;

endmodule

// File: dv/ace_checker.sv
module ace_checker
  import ace_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] height_cm_i,
  input  logic signed [31:0] accel_z_mss_i,
  input  logic signed [15:0] roll_cdeg_i,
  input  logic signed [15:0] pitch_cdeg_i,
  input  logic signed [15:0] throttle_cmd_i,
  input  logic               system_ready_i,
  input  logic               armed_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               valid_res_i,
  input  logic signed [31:0] position_est_i,
  input  logic signed [31:0] velocity_est_i,
  input  logic [25:0]        hover_throttle_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int Depth = HistDepthDefault;

  typedef struct packed {
    logic        valid;
    logic [31:0] position;
    logic [31:0] velocity;
    logic [25:0] hover;
  } estimate_t;

  estimate_t estimate_q[$];

  // Shadow copy of the configuration and the filter state.
  longint period, alpha, idle_thr, init_hover;
  longint baro_f, pos_corr, pos_base, h_int, bias_corr, pos_val, vel_val, hover_val;
  longint base_hist[Depth];

  function automatic longint round_shift(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint clip_hover(longint h);
    if (h < 0) return 0;
    if (h > longint'(HoverMax)) return longint'(HoverMax);
    return h;
  endfunction

  function automatic longint scaled_by_dt(longint x, longint gain);
    return round_shift(x * gain * period, 32);
  endfunction

  task automatic reset_estimator();
    period = 164;
    alpha = 28835;
    idle_thr = 100;
    init_hover = 400;
    baro_f = 0;
    pos_corr = 0;
    pos_base = 0;
    h_int = 0;
    bias_corr = 0;
    pos_val = 0;
    vel_val = 0;
    foreach (base_hist[i]) base_hist[i] = 0;
    hover_val = clip_hover(init_hover <<< 16);
  endtask

  task automatic write_register(logic [1:0] idx, logic [15:0] data);
    case (idx)
      CfgSamplePeriod: period = data;
      CfgBaroAlpha: alpha = data;
      CfgIdleThrottle: idle_thr = data[9:0];
      CfgInitialHover: begin
        init_hover = data[9:0];
        hover_val = clip_hover(init_hover <<< 16);
      end
      default: ;
    endcase
  endtask

  // Advances the altitude filter by one item and returns the estimate it yields.
  function automatic estimate_t estimate_altitude();
    estimate_t e;
    longint acc_ef, err, vel_inc, av, ar, ap, thr;
    if (system_ready_i) begin
      acc_ef = clip32(-((longint'(accel_z_mss_i) + longint'(GravityQ16)) * 100));
      baro_f = clip32(baro_f + round_shift((longint'(height_cm_i) - baro_f) * alpha, 16));
      if (!armed_i) begin
        pos_base = baro_f;
        pos_val = baro_f;
        bias_corr = clip32(-acc_ef);
        vel_val = 0;
        h_int = 0;
      end
      err = clip32(baro_f - (base_hist[0] + pos_corr));
      bias_corr = clip32(bias_corr + scaled_by_dt(err, GainAcc));
      vel_val = clip32(vel_val + scaled_by_dt(err, GainVel));
      pos_corr = clip32(pos_corr + scaled_by_dt(err, GainPos));
      vel_inc = clip32(round_shift((acc_ef + bias_corr) * period, 16));
      pos_base = clip32(pos_base + round_shift((2 * vel_val + vel_inc) * period, 17));
      pos_val = clip32(pos_base + pos_corr + round_shift(h_int * longint'(GainInt), 16));
      h_int = clip32(h_int + round_shift((baro_f - pos_val) * period, 16));
      vel_val = clip32(vel_val + vel_inc);
      for (int i = 0; i < Depth - 1; i++) base_hist[i] = base_hist[i + 1];
      base_hist[Depth - 1] = pos_base;

      // Hover tracking only while level, slow and above idle throttle.
      av = vel_val < 0 ? -vel_val : vel_val;
      ar = roll_cdeg_i < 0 ? -longint'(roll_cdeg_i) : longint'(roll_cdeg_i);
      ap = pitch_cdeg_i < 0 ? -longint'(pitch_cdeg_i) : longint'(pitch_cdeg_i);
      thr = throttle_cmd_i;
      if (thr > idle_thr && av < longint'(SpeedLimit) && ar < longint'(AngleLimit) &&
          ap < longint'(AngleLimit)) begin
        hover_val = clip_hover(round_shift(hover_val * longint'(HoverKeep) +
                                           thr * 65536 * longint'(HoverTake), 16));
      end
    end
    e.valid = system_ready_i;
    e.position = pos_val[31:0];
    e.velocity = vel_val[31:0];
    e.hover = hover_val[25:0];
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch in %s: got %h, expected %h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  // Compare results, then predict the item taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    estimate_t want;
    if (!rst_ni) begin
      reset_estimator();
      estimate_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (estimate_q.size() == 0) begin
          report_mismatch("unexpected item", 32'(valid_res_i), 32'd0);
        end else begin
          want = estimate_q.pop_front();
          if (valid_res_i !== want.valid)
            report_mismatch("valid_res", 32'(valid_res_i), 32'(want.valid));
          if (position_est_i !== want.position)
            report_mismatch("position_est", position_est_i, want.position);
          if (velocity_est_i !== want.velocity)
            report_mismatch("velocity_est", velocity_est_i, want.velocity);
          if (hover_throttle_i !== want.hover)
            report_mismatch("hover_throttle", 32'(hover_throttle_i), 32'(want.hover));
        end
      end
      if (cfg_we_i) write_register(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_i) estimate_q.push_back(estimate_altitude());
    end
    pending_o = estimate_q.size();
  end

endmodule

// File: dv/tb_top.sv
module tb_top;
  import ace_pkg::*;

  localparam int CycleLimit = 1000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = CfgSamplePeriod;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] height_cm_i = '0;
  logic signed [31:0] accel_z_mss_i = '0;
  logic signed [15:0] roll_cdeg_i = '0;
  logic signed [15:0] pitch_cdeg_i = '0;
  logic signed [15:0] throttle_cmd_i = '0;
  logic               system_ready_i = 1'b0;
  logic               armed_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               valid_res_o;
  logic signed [31:0] position_est_o;
  logic signed [31:0] velocity_est_o;
  logic [25:0]        hover_throttle_o;

  int fail_count, pending;
  int cycles = 0;
  bit hold_off_req = 1'b0;
  longint altitude = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  altitude_complementary_estimator dut (.*);

  ace_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .height_cm_i, .accel_z_mss_i, .roll_cdeg_i,
    .pitch_cdeg_i, .throttle_cmd_i, .system_ready_i, .armed_i,
    .out_valid_i(out_valid_o), .out_stall_i, .valid_res_i(valid_res_o),
    .position_est_i(position_est_o), .velocity_est_i(velocity_est_o),
    .hover_throttle_i(hover_throttle_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver stalls: bursts of stall and no stall, one long hold-off on request.
  initial begin
    int len;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      len = pick_gap() + 1;
      out_stall_i <= ($urandom_range(0, 2) == 0);
      repeat (len) @(posedge clk_i);
    end
  end

  task automatic write_register(logic [1:0] idx, logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offers one item and waits until the block takes it.
  task automatic send_reading(logic [31:0] h, logic [31:0] a, logic [15:0] r,
                              logic [15:0] p, logic [15:0] t, logic rdy, logic arm);
    int gap;
    height_cm_i <= h;
    accel_z_mss_i <= a;
    roll_cdeg_i <= r;
    pitch_cdeg_i <= p;
    throttle_cmd_i <= t;
    system_ready_i <= rdy;
    armed_i <= arm;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // A plausible flight sample most of the time, raw noise otherwise.
  task automatic send_random_reading();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      altitude += $signed($urandom_range(0, 400000)) - 200000;
      send_reading(altitude[31:0], 32'(-642689 + $signed($urandom_range(0, 40000)) - 20000),
                   16'($signed($urandom_range(0, 1200)) - 600),
                   16'($signed($urandom_range(0, 1200)) - 600),
                   16'($urandom_range(0, 900)), $urandom_range(0, 19) != 0,
                   $urandom_range(0, 14) != 0);
    end else begin
      send_reading($urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                   1'($urandom), 1'($urandom));
    end
  endtask

  // Drops valid and lets the last accepted item be counted, then waits until all results are back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] periods[6] = '{16'd164, 16'd1, 16'd65535, 16'd0, 16'd3000, 16'd655};
    logic [15:0] alphas[6]  = '{16'd28835, 16'd0, 16'd65535, 16'd40000, 16'd1000, 16'd65535};
    logic [15:0] idles[6]   = '{16'd100, 16'd0, 16'd1000, 16'd1023, 16'd300, 16'd50};
    logic [15:0] hovers[6]  = '{16'd400, 16'd0, 16'd1000, 16'd1023, 16'd500, 16'd700};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners at reset settings.
    send_reading(0, 0, 0, 0, 0, 1'b0, 1'b0);
    send_reading(0, -642689, 0, 0, 400, 1'b1, 1'b0);
    send_reading(32'h7FFF_FFFF, 32'h7FFF_FFFF, 18000, 18000, 32767, 1'b1, 1'b1);
    send_reading(32'h8000_0000, 32'h8000_0000, -18000, -18000, -32768, 1'b1, 1'b1);
    send_reading(32'h8000_0000, 32'h8000_0000, 0, 0, 0, 1'b1, 1'b0);
    send_reading(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 1'b1, 1'b0);
    send_reading(0, -642689, 0, 0, 500, 1'b1, 1'b0);
    send_reading(65536, -642689, 499, -499, 101, 1'b1, 1'b1);
    send_reading(65536, -642689, 500, 0, 600, 1'b1, 1'b1);
    send_reading(65536, -642689, 0, -500, 600, 1'b1, 1'b1);
    send_reading(65536, -642689, 0, 0, 100, 1'b1, 1'b1);
    send_reading(65536, -642689, 0, 0, 32767, 1'b1, 1'b1);
    send_reading(65536, -642689, 0, 0, -32768, 1'b1, 1'b1);
    send_reading(32'h7FFF_FFFF, 0, 0, 0, 900, 1'b0, 1'b1);
    send_reading(0, -642689, 0, 0, 700, 1'b1, 1'b1);
    drain();

    // Random phases under different settings.
    for (int ph = 0; ph < 6; ph++) begin
      write_register(CfgSamplePeriod, periods[ph]);
      write_register(CfgBaroAlpha, alphas[ph]);
      write_register(CfgIdleThrottle, idles[ph]);
      write_register(CfgInitialHover, hovers[ph]);
      altitude = 0;
      for (int n = 0; n < 125; n++) begin
        if (ph == 2 && n == 20) hold_off_req = 1'b1;
        send_random_reading();
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ace_pkg.sv
hw/rtl/ace_mul.sv
hw/rtl/altitude_complementary_estimator.sv
dv/ace_checker.sv
dv/tb_top.sv
